>>> rtl/ipa_pkg.sv
// shared types, codes and constants of the interplanar angle pipeline
// no dependencies; the top, front and cordic files refer to it by scoped names
package ipa_pkg;

  localparam int ANGLE_STEPS = 26;
  localparam int Q_BITS      = 61;
  localparam int C_BITS      = 31;
  localparam int XW          = 34;
  localparam int ZW          = 33;

  localparam logic [31:0] RIGHT_Q24    = 32'd1509949440;
  localparam logic [31:0] STRAIGHT_Q24 = 32'd3019898880;
  localparam logic [23:0] STRAIGHT_Q16 = 24'd11796480;
  localparam logic [Q_BITS-1:0] ONE_SQ = {1'b1, {(Q_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_INV_A = 3'd0,
    REG_INV_B = 3'd1,
    REG_INV_C = 3'd2,
    REG_REF_H = 3'd3,
    REG_REF_K = 3'd4,
    REG_REF_L = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO     = 2'd1,
    STAT_STRAIGHT = 2'd2
  } status_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } tag_t;

  // arctangent of 2^-i in Q8.24 degrees
  function automatic logic [31:0] atan_q24(input int idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'd754974720;
      1:  a = 32'd445687602;
      2:  a = 32'd235489088;
      3:  a = 32'd119537938;
      4:  a = 32'd60000934;
      5:  a = 32'd30029717;
      6:  a = 32'd15018523;
      7:  a = 32'd7509720;
      8:  a = 32'd3754917;
      9:  a = 32'd1877466;
      10: a = 32'd938734;
      11: a = 32'd469367;
      12: a = 32'd234684;
      13: a = 32'd117342;
      14: a = 32'd58671;
      15: a = 32'd29335;
      16: a = 32'd14668;
      17: a = 32'd7334;
      18: a = 32'd3667;
      19: a = 32'd1833;
      20: a = 32'd917;
      21: a = 32'd458;
      22: a = 32'd229;
      23: a = 32'd115;
      24: a = 32'd57;
      25: a = 32'd29;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/interplanar_angle_top.sv
// interplanar angle top level: config registers, stage chaining, result register
// depends on ipa_pkg, ipa_front, ipa_div, ipa_sqrt, ipa_cordic
//
//   channel  dir  tdata / data                          tuser / index
//   in_      in   h1,k1,l1,h2,k2,l2 (INDEX_BITS each)   mode
//   out_     out  angle_degrees q8.16                   status
//   cfg_     in   register value, 32 bits               register index, 3 bits
//
// one request per cycle unless the result stalls; at INDEX_BITS 6 the stages are
// 5 front stages, 61 divider stages, 31 root stages, cosine square, 31 root
// stages, 26 cordic stages and the result register. the divider sets the depth
// a stalled result holds the whole pipeline; nothing is dropped or repeated
// reset clears the valid bits and loads the register defaults
module interplanar_angle_top #(
  parameter int INDEX_BITS = 6,
  localparam int IN_W = ((6*INDEX_BITS + 7)/8)*8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,   // h_one, k_one, l_one, h_two, k_two, l_two
  input  logic            in_tuser,   // mode
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [23:0]     out_tdata,  // angle_degrees
  output logic [1:0]      out_tuser,  // status
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int IB = INDEX_BITS;
  localparam int NW = 2*IB + 32;
  localparam int PW = 2*NW;
  localparam int CB = ipa_pkg::C_BITS;
  localparam int QB = ipa_pkg::Q_BITS;
  localparam int ZW = ipa_pkg::ZW;
  localparam int TW = $bits(ipa_pkg::tag_t);

  logic          en;
  logic [31:0]   inv_a_r, inv_b_r, inv_c_r;
  logic [IB-1:0] ref_h_r, ref_k_r, ref_l_r;

  logic          fr_valid;
  ipa_pkg::tag_t fr_tag;
  logic [PW-1:0] fr_prod, fr_dsq;

  logic          dv_valid;
  logic [QB-1:0] dv_quot;
  logic [TW-1:0] dv_side;

  logic          s1_valid;
  logic [CB-1:0] s1_root;
  logic [TW-1:0] s1_side;

  logic              cs_v_r;
  logic [CB-1:0]     cs_c_r;
  logic [QB-1:0]     cs_t_r;
  logic [TW-1:0]     cs_side_r;
  logic [2*CB-1:0]   c_sq;

  logic             s2_valid;
  logic [CB-1:0]    s2_root;
  logic [TW+CB-1:0] s2_side;

  logic                 co_valid;
  logic signed [ZW-1:0] co_z;
  logic [TW-1:0]        co_side;
  ipa_pkg::tag_t        co_tag;

  logic [31:0]   z_clamp, theta;
  logic [32:0]   rnd;
  logic [23:0]   angle_nxt;
  logic [1:0]    status_nxt;

  logic          out_valid_r;
  logic [23:0]   angle_r;
  logic [1:0]    status_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_a_r <= 32'd28862980;
      inv_b_r <= 32'd464723120;
      inv_c_r <= 32'd127671500;
      ref_h_r <= '0;
      ref_k_r <= '0;
      ref_l_r <= IB'(1);
    end else if (cfg_valid) begin
      case (ipa_pkg::reg_idx_t'(cfg_index))
        ipa_pkg::REG_INV_A: inv_a_r <= cfg_data;
        ipa_pkg::REG_INV_B: inv_b_r <= cfg_data;
        ipa_pkg::REG_INV_C: inv_c_r <= cfg_data;
        ipa_pkg::REG_REF_H: ref_h_r <= cfg_data[IB-1:0];
        ipa_pkg::REG_REF_K: ref_k_r <= cfg_data[IB-1:0];
        ipa_pkg::REG_REF_L: ref_l_r <= cfg_data[IB-1:0];
        default: ;
      endcase
    end
  end

  ipa_front #(.INDEX_BITS(IB)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .mode      (in_tuser),
    .h_one     ($signed(in_tdata[IB-1:0])),
    .k_one     ($signed(in_tdata[2*IB-1:IB])),
    .l_one     ($signed(in_tdata[3*IB-1:2*IB])),
    .h_two     ($signed(in_tdata[4*IB-1:3*IB])),
    .k_two     ($signed(in_tdata[5*IB-1:4*IB])),
    .l_two     ($signed(in_tdata[6*IB-1:5*IB])),
    .ref_h     ($signed(ref_h_r)),
    .ref_k     ($signed(ref_k_r)),
    .ref_l     ($signed(ref_l_r)),
    .w_a       (inv_a_r),
    .w_b       (inv_b_r),
    .w_c       (inv_c_r),
    .out_valid (fr_valid),
    .out_tag   (fr_tag),
    .prod      (fr_prod),
    .dsq       (fr_dsq)
  );

  // cos^2 in q1.60: dot^2 * 2^60 / (n0 * n1)
  ipa_div #(.PW(PW), .QB(QB), .SW(TW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .num       (fr_dsq),
    .den       (fr_prod),
    .in_side   (fr_tag),
    .out_valid (dv_valid),
    .quot      (dv_quot),
    .out_side  (dv_side)
  );

  ipa_sqrt #(.VW(QB), .RB(CB), .SW(TW)) u_sqrt_cos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .rad       (dv_quot),
    .in_side   (dv_side),
    .out_valid (s1_valid),
    .root      (s1_root),
    .out_side  (s1_side)
  );

  assign c_sq = (2*CB)'(s1_root) * (2*CB)'(s1_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_v_r <= 1'b0;
    end else if (en) begin
      cs_v_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_c_r    <= s1_root;
      cs_t_r    <= ipa_pkg::ONE_SQ - c_sq[QB-1:0];
      cs_side_r <= s1_side;
    end
  end

  ipa_sqrt #(.VW(QB), .RB(CB), .SW(TW+CB)) u_sqrt_sin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cs_v_r),
    .rad       (cs_t_r),
    .in_side   ({cs_side_r, cs_c_r}),
    .out_valid (s2_valid),
    .root      (s2_root),
    .out_side  (s2_side)
  );

  ipa_cordic #(.SW(TW)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_valid),
    .x_in      (s2_side[CB-1:0]),
    .y_in      (s2_root),
    .in_side   (s2_side[TW+CB-1:CB]),
    .out_valid (co_valid),
    .z_out     (co_z),
    .out_side  (co_side)
  );

  assign co_tag = ipa_pkg::tag_t'(co_side);

  always_comb begin
    if (co_z[ZW-1]) begin
      z_clamp = '0;
    end else if (co_z[31:0] > ipa_pkg::RIGHT_Q24) begin
      z_clamp = ipa_pkg::RIGHT_Q24;
    end else begin
      z_clamp = co_z[31:0];
    end
    theta = co_tag.neg ? ipa_pkg::STRAIGHT_Q24 - z_clamp : z_clamp;
    // round half up from q8.24 to q8.16
    rnd   = {1'b0, theta} + 33'd128;
    if (rnd[32:8] > {1'b0, ipa_pkg::STRAIGHT_Q16}) begin
      angle_nxt = ipa_pkg::STRAIGHT_Q16;
    end else begin
      angle_nxt = rnd[31:8];
    end
    if (co_tag.zero) begin
      angle_nxt  = '0;
      status_nxt = ipa_pkg::STAT_ZERO;
    end else if (angle_nxt == ipa_pkg::STRAIGHT_Q16) begin
      status_nxt = ipa_pkg::STAT_STRAIGHT;
    end else begin
      status_nxt = ipa_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= co_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r  <= angle_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = angle_r;
  assign out_tuser  = status_r;

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ipa_pkg::STAT_ZERO) |-> (angle_r == '0))
    else $error("zero norm result carries a nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (angle_r <= ipa_pkg::STRAIGHT_Q16))
    else $error("angle above 180 degrees");

  a_straight_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ipa_pkg::STAT_ZERO) |->
      ((status_r == ipa_pkg::STAT_STRAIGHT) == (angle_r == ipa_pkg::STRAIGHT_Q16)))
    else $error("straight angle status disagrees with angle");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cs_c_r) && $stable(cs_v_r))
    else $error("inner stage moved during a stall");

endmodule

>>> rtl/ipa_front.sv
// front stages: index products, weighting, sums, squared dot and norm product
// depends on ipa_pkg
module ipa_front #(
  parameter int INDEX_BITS = 6,
  localparam int NW = 2*INDEX_BITS + 32,
  localparam int PW = 2*NW
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         mode,
  input  logic signed [INDEX_BITS-1:0] h_one,
  input  logic signed [INDEX_BITS-1:0] k_one,
  input  logic signed [INDEX_BITS-1:0] l_one,
  input  logic signed [INDEX_BITS-1:0] h_two,
  input  logic signed [INDEX_BITS-1:0] k_two,
  input  logic signed [INDEX_BITS-1:0] l_two,
  input  logic signed [INDEX_BITS-1:0] ref_h,
  input  logic signed [INDEX_BITS-1:0] ref_k,
  input  logic signed [INDEX_BITS-1:0] ref_l,
  input  logic [31:0]                  w_a,
  input  logic [31:0]                  w_b,
  input  logic [31:0]                  w_c,
  output logic                         out_valid,
  output ipa_pkg::tag_t                out_tag,
  output logic [PW-1:0]                prod,
  output logic [PW-1:0]                dsq
);

  localparam int IPW = 2*INDEX_BITS;
  localparam int SQW = 2*INDEX_BITS - 1;
  localparam int DW  = 2*INDEX_BITS + 33;
  localparam int HW  = NW/2;

  logic signed [INDEX_BITS-1:0] p0 [3];
  logic signed [INDEX_BITS-1:0] p1 [3];
  logic [31:0]                  w [3];
  logic signed [IPW-1:0]        dp_c [3];
  logic signed [IPW-1:0]        s0_c [3];
  logic signed [IPW-1:0]        s1_c [3];

  logic                  va_r, vb_r, vc_r, vd_r, ve_r;
  logic signed [IPW-1:0] a_dp_r [3];
  logic [SQW-1:0]        a_s0_r [3];
  logic [SQW-1:0]        a_s1_r [3];
  logic signed [DW-1:0]  b_d_r [3];
  logic [SQW+31:0]       b_n0_r [3];
  logic [SQW+31:0]       b_n1_r [3];

  logic signed [DW-1:0]  dot_nxt;
  logic [NW-1:0]         n0_nxt, n1_nxt, mag_nxt;
  logic [NW-1:0]         c_mag_r, c_n0_r, c_n1_r;
  ipa_pkg::tag_t         c_tag_r, d_tag_r, e_tag_r;

  logic [NW-1:0] d_mll_r, d_mlh_r, d_mhh_r, d_nll_r, d_nlh_r, d_nhl_r, d_nhh_r;
  logic [PW-1:0] e_prod_r, e_dsq_r;

  always_comb begin
    p1[0] = h_one;
    p1[1] = k_one;
    p1[2] = l_one;
    if (mode) begin
      p0[0] = h_two;
      p0[1] = k_two;
      p0[2] = l_two;
    end else begin
      p0[0] = ref_h;
      p0[1] = ref_k;
      p0[2] = ref_l;
    end
    w[0] = w_a;
    w[1] = w_b;
    w[2] = w_c;
    for (int i = 0; i < 3; i++) begin
      dp_c[i] = p0[i] * p1[i];
      s0_c[i] = p0[i] * p0[i];
      s1_c[i] = p1[i] * p1[i];
    end
  end

  always_comb begin
    dot_nxt = b_d_r[0] + b_d_r[1] + b_d_r[2];
    n0_nxt  = NW'(b_n0_r[0]) + NW'(b_n0_r[1]) + NW'(b_n0_r[2]);
    n1_nxt  = NW'(b_n1_r[0]) + NW'(b_n1_r[1]) + NW'(b_n1_r[2]);
    mag_nxt = dot_nxt[DW-1] ? NW'(-dot_nxt) : NW'(dot_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_dp_r[i] <= dp_c[i];
        a_s0_r[i] <= s0_c[i][SQW-1:0];
        a_s1_r[i] <= s1_c[i][SQW-1:0];
        b_d_r[i]  <= DW'(a_dp_r[i]) * $signed({1'b0, w[i]});
        b_n0_r[i] <= (SQW+32)'(a_s0_r[i]) * w[i];
        b_n1_r[i] <= (SQW+32)'(a_s1_r[i]) * w[i];
      end
      c_mag_r      <= mag_nxt;
      c_n0_r       <= n0_nxt;
      c_n1_r       <= n1_nxt;
      c_tag_r.neg  <= dot_nxt[DW-1];
      c_tag_r.zero <= (n0_nxt == '0) || (n1_nxt == '0);
      // partial products of the wide dot square and the norm product
      d_mll_r <= NW'(c_mag_r[HW-1:0])  * NW'(c_mag_r[HW-1:0]);
      d_mlh_r <= NW'(c_mag_r[HW-1:0])  * NW'(c_mag_r[NW-1:HW]);
      d_mhh_r <= NW'(c_mag_r[NW-1:HW]) * NW'(c_mag_r[NW-1:HW]);
      d_nll_r <= NW'(c_n0_r[HW-1:0])   * NW'(c_n1_r[HW-1:0]);
      d_nlh_r <= NW'(c_n0_r[HW-1:0])   * NW'(c_n1_r[NW-1:HW]);
      d_nhl_r <= NW'(c_n0_r[NW-1:HW])  * NW'(c_n1_r[HW-1:0]);
      d_nhh_r <= NW'(c_n0_r[NW-1:HW])  * NW'(c_n1_r[NW-1:HW]);
      d_tag_r <= c_tag_r;
      e_dsq_r  <= (PW'(d_mhh_r) << NW) + (PW'(d_mlh_r) << (HW+1)) + PW'(d_mll_r);
      e_prod_r <= (PW'(d_nhh_r) << NW) + ((PW'(d_nlh_r) + PW'(d_nhl_r)) << HW)
                  + PW'(d_nll_r);
      e_tag_r  <= d_tag_r;
    end
  end

  assign out_valid = ve_r;
  assign out_tag   = e_tag_r;
  assign prod      = e_prod_r;
  assign dsq       = e_dsq_r;

endmodule

>>> rtl/ipa_div.sv
// pipelined restoring divider, one quotient bit per stage, num <= den assumed
// depends on nothing but its parameters
module ipa_div #(
  parameter int PW = 88,
  parameter int QB = 61,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [PW-1:0] num,
  input  logic [PW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] quot,
  output logic [SW-1:0] out_side
);

  logic          v_r [QB];
  logic [PW-1:0] rem_r [QB];
  logic [PW-1:0] den_r [QB];
  logic [QB-1:0] q_r [QB];
  logic [SW-1:0] side_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [PW:0]   rem_in;
    logic [PW-1:0] den_in;
    logic [QB-1:0] q_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic          ge;
    logic [PW:0]   rem_nxt;

    if (j == 0) begin : g_first
      // first bit is the integer part: no shift
      assign rem_in  = {1'b0, num};
      assign den_in  = den;
      assign q_in    = '0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = {rem_r[j-1], 1'b0};
      assign den_in  = den_r[j-1];
      assign q_in    = q_r[j-1];
      assign side_in = side_r[j-1];
      assign v_in    = v_r[j-1];
    end

    always_comb begin
      ge      = rem_in >= {1'b0, den_in};
      rem_nxt = ge ? rem_in - {1'b0, den_in} : rem_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt[PW-1:0];
        den_r[j]  <= den_in;
        q_r[j]    <= {q_in[QB-2:0], ge};
        side_r[j] <= side_in;
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign quot      = q_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule

>>> rtl/ipa_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on nothing but its parameters
module ipa_sqrt #(
  parameter int VW = 61,
  parameter int RB = 31,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RB-1:0] root,
  output logic [SW-1:0] out_side
);

  localparam int AW = VW + 1;

  logic          v_r [RB];
  logic [AW-1:0] val_r [RB];
  logic [AW-1:0] res_r [RB];
  logic [SW-1:0] side_r [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam logic [AW-1:0] BITV = AW'(1) << (2*(RB-1-k));
    logic [AW-1:0] val_in, res_in, trial;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign val_in  = AW'(rad);
      assign res_in  = '0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign val_in  = val_r[k-1];
      assign res_in  = res_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = v_r[k-1];
    end

    always_comb begin
      trial = res_in + BITV;
      ge    = val_in >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k]  <= ge ? val_in - trial : val_in;
        res_r[k]  <= ge ? (res_in >> 1) + BITV : res_in >> 1;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[RB-1];
  assign root      = res_r[RB-1][RB-1:0];
  assign out_side  = side_r[RB-1];

endmodule

>>> rtl/ipa_cordic.sv
// pipelined cordic vectoring, one rotation per stage, angle in q8.24 degrees
// depends on ipa_pkg for the arctangent table and widths
module ipa_cordic #(
  parameter int SW = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [ipa_pkg::C_BITS-1:0]     x_in,
  input  logic [ipa_pkg::C_BITS-1:0]     y_in,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_valid,
  output logic signed [ipa_pkg::ZW-1:0]  z_out,
  output logic [SW-1:0]                  out_side
);

  localparam int NS = ipa_pkg::ANGLE_STEPS;
  localparam int XW = ipa_pkg::XW;
  localparam int ZW = ipa_pkg::ZW;

  logic                 v_r [NS];
  logic signed [XW-1:0] x_r [NS];
  logic signed [XW-1:0] y_r [NS];
  logic signed [ZW-1:0] z_r [NS];
  logic [SW-1:0]        side_r [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATN = $signed(ZW'(ipa_pkg::atan_q24(i)));
    logic signed [XW-1:0] xi, yi, xs, ys;
    logic signed [ZW-1:0] zi;
    logic [SW-1:0]        side_in;
    logic                 v_in;

    if (i == 0) begin : g_first
      assign xi      = $signed(XW'(x_in));
      assign yi      = $signed(XW'(y_in));
      assign zi      = '0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign xi      = x_r[i-1];
      assign yi      = y_r[i-1];
      assign zi      = z_r[i-1];
      assign side_in = side_r[i-1];
      assign v_in    = v_r[i-1];
    end

    always_comb begin
      xs = xi >>> i;
      ys = yi >>> i;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[XW-1]) begin
          x_r[i] <= xi + ys;
          y_r[i] <= yi - xs;
          z_r[i] <= zi + ATN;
        end else begin
          x_r[i] <= xi - ys;
          y_r[i] <= yi + xs;
          z_r[i] <= zi - ATN;
        end
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign z_out     = z_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

>>> test/interplanar_angle_top_tb.sv
// self-checking bench for interplanar_angle_top: directed table, then random phases
// over several register settings; depends on ipa_pkg and the rtl of the block
module interplanar_angle_top_tb;

  localparam int IB   = 6;
  localparam int IN_W = ((6*IB + 7)/8)*8;
  localparam int LATENCY = 156;
  localparam int CYCLE_LIMIT = 600000;

  typedef logic signed [IB-1:0] idx_t;
  typedef struct {
    logic [23:0]      angle;
    ipa_pkg::status_t status;
  } angle_res_t;
  typedef struct {
    logic    mode;
    idx_t    pl[6];
    bit      typed;
    angle_res_t res;
  } dir_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [23:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  interplanar_angle_top #(.INDEX_BITS(IB)) uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor copy of the registers
  logic [31:0] w_sq[3];
  idx_t ref_plane[3];

  const longint atan_tab[26] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29};

  angle_res_t angle_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int stall_kind = 0;
  int stall_left = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic angle_res_t plane_angle(logic mode, idx_t pl[6]);
    angle_res_t o;
    longint a0[3], a1[3];
    longint dot = 0;
    longint unsigned n0 = 0, n1 = 0, mag, c = 0, trial, s;
    logic [191:0] prod, big_q, lhs;
    longint x, y, z = 0, xs, ys, theta;
    longint unsigned ang;
    for (int i = 0; i < 3; i++) begin
      a1[i] = pl[i];
      a0[i] = mode ? longint'(pl[3+i]) : longint'(ref_plane[i]);
    end
    for (int i = 0; i < 3; i++) begin
      dot += a0[i] * a1[i] * $signed({32'b0, w_sq[i]});
      n0 += longint'(a0[i] * a0[i]) * {32'b0, w_sq[i]};
      n1 += longint'(a1[i] * a1[i]) * {32'b0, w_sq[i]};
    end
    if (n0 == 0 || n1 == 0) begin
      o.angle = '0;
      o.status = ipa_pkg::STAT_ZERO;
      return o;
    end
    prod = {128'b0, n0} * {128'b0, n1};
    mag = dot < 0 ? -dot : dot;
    big_q = ({128'b0, mag} * {128'b0, mag}) << 60;
    for (int b = 30; b >= 0; b--) begin
      trial = c | (64'd1 << b);
      if (trial <= (64'd1 << 30)) begin
        lhs = {128'b0, trial * trial} * prod;
        if (lhs <= big_q) c = trial;
      end
    end
    s = int_sqrt((64'd1 << 60) - c * c);
    x = c;
    y = s;
    for (int i = 0; i < 26; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << 24)) z = longint'(90) << 24;
    theta = dot < 0 ? (longint'(180) << 24) - z : z;
    ang = (theta + 128) >> 8;
    if (ang > (64'd180 << 16)) ang = 64'd180 << 16;
    o.angle = ang[23:0];
    o.status = (ang == (64'd180 << 16)) ? ipa_pkg::STAT_STRAIGHT : ipa_pkg::STAT_OK;
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ipa_pkg::REG_INV_A: w_sq[0] = val;
      ipa_pkg::REG_INV_B: w_sq[1] = val;
      ipa_pkg::REG_INV_C: w_sq[2] = val;
      ipa_pkg::REG_REF_H: ref_plane[0] = val[IB-1:0];
      ipa_pkg::REG_REF_K: ref_plane[1] = val[IB-1:0];
      ipa_pkg::REG_REF_L: ref_plane[2] = val[IB-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // sender bursts: a gap of random length opens each burst
  task automatic send_planes(logic mode, idx_t pl[6], bit typed, angle_res_t tres);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid = 1;
    in_tuser = mode;
    in_tdata = '0;
    for (int i = 0; i < 6; i++) in_tdata[i*IB +: IB] = pl[i];
    do @(posedge clk); while (!in_tready);
    angle_q.push_back(typed ? tres : plane_angle(mode, pl));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 0;
    burst_left = 0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic idx_t pick_index();
    case ($urandom_range(0, 9))
      0: return -32;
      1: return 31;
      2: return 0;
      3, 4, 5: return idx_t'(int'($urandom_range(0, 6)) - 3);
      default: return idx_t'($urandom());
    endcase
  endfunction

  task automatic random_planes(int n);
    idx_t pl[6];
    angle_res_t none;
    none = '{angle: '0, status: ipa_pkg::STAT_OK};
    repeat (n) begin
      for (int i = 0; i < 6; i++) pl[i] = pick_index();
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 0; i < 3; i++) pl[i] = 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        // second plane copies the first with a random sign per index
        for (int i = 0; i < 3; i++) pl[3+i] = ($urandom() & 1) ? pl[i] : -pl[i];
      end
      send_planes(1'($urandom()), pl, 0, none);
    end
  endtask

  task automatic load_cell(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] h, logic [31:0] k, logic [31:0] l);
    write_reg(ipa_pkg::REG_INV_A, a);
    write_reg(ipa_pkg::REG_INV_B, b);
    write_reg(ipa_pkg::REG_INV_C, c);
    write_reg(ipa_pkg::REG_REF_H, h);
    write_reg(ipa_pkg::REG_REF_K, k);
    write_reg(ipa_pkg::REG_REF_L, l);
    // unused index must leave everything alone
    write_reg(($urandom() & 1) ? 3'd7 : 3'd6, $urandom());
  endtask

  dir_row_t dir_rows[$];

  task automatic build_table();
    dir_row_t r;
    angle_res_t zr, none;
    zr = '{angle: '0, status: ipa_pkg::STAT_ZERO};
    none = '{angle: '0, status: ipa_pkg::STAT_OK};
    r = '{mode: 0, pl: '{0, 0, 0, 5, 5, 5}, typed: 1, res: zr}; dir_rows.push_back(r);
    r = '{mode: 1, pl: '{1, 2, 3, 0, 0, 0}, typed: 1, res: zr}; dir_rows.push_back(r);
    r = '{mode: 1, pl: '{0, 0, 0, 0, 0, 0}, typed: 1, res: zr}; dir_rows.push_back(r);
    r = '{mode: 0, pl: '{0, 0, 1, 0, 0, 0}, typed: 0, res: none}; dir_rows.push_back(r);
    r = '{mode: 0, pl: '{0, 0, -1, 7, 7, 7}, typed: 0, res: none}; dir_rows.push_back(r);
    r = '{mode: 0, pl: '{1, 0, 0, 0, 0, 0}, typed: 0, res: none}; dir_rows.push_back(r);
    r = '{mode: 1, pl: '{1, 0, 0, 1, 0, 0}, typed: 0, res: none}; dir_rows.push_back(r);
    r = '{mode: 1, pl: '{1, 0, 0, -1, 0, 0}, typed: 0, res: none}; dir_rows.push_back(r);
    r = '{mode: 1, pl: '{31, 31, 31, -32, -32, -32}, typed: 0, res: none};
    dir_rows.push_back(r);
    r = '{mode: 1, pl: '{-32, -32, -32, -32, -32, -32}, typed: 0, res: none};
    dir_rows.push_back(r);
    r = '{mode: 1, pl: '{31, -32, 31, -32, 31, -32}, typed: 0, res: none};
    dir_rows.push_back(r);
    r = '{mode: 1, pl: '{1, 1, 0, 1, -1, 0}, typed: 0, res: none}; dir_rows.push_back(r);
    r = '{mode: 1, pl: '{1, 2, 3, -3, -2, -1}, typed: 0, res: none}; dir_rows.push_back(r);
    r = '{mode: 0, pl: '{-32, 31, -1, 0, 0, 0}, typed: 0, res: none}; dir_rows.push_back(r);
    r = '{mode: 1, pl: '{0, 1, 0, 0, 31, 1}, typed: 0, res: none}; dir_rows.push_back(r);
    r = '{mode: 1, pl: '{21, 10, 0, 42, 20, 0}, typed: 0, res: none}; dir_rows.push_back(r);
  endtask

  // receiver: stall pattern switches among always ready, coin flip and sparse
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      0: out_tready <= rst_n;
      1: out_tready <= rst_n && ($urandom() & 1);
      default: out_tready <= rst_n && ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    angle_res_t e;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("interplanar_angle_top regression: fail");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (angle_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result angle %0d status %0d", out_tdata, out_tuser);
      end else begin
        e = angle_q.pop_front();
        if (out_tdata !== e.angle || out_tuser !== e.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected angle %0d status %0d, got angle %0d status %0d",
                     e.angle, e.status, out_tdata, out_tuser);
        end
      end
    end
  end

  initial begin
    w_sq = '{32'd28862980, 32'd464723120, 32'd127671500};
    ref_plane = '{0, 0, 1};
    build_table();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset values first, untouched
    foreach (dir_rows[i])
      send_planes(dir_rows[i].mode, dir_rows[i].pl, dir_rows[i].typed, dir_rows[i].res);
    random_planes(60);
    drain_results();

    // a zero weight makes a plane along that axis have zero norm
    load_cell(32'd0, 32'd464723120, 32'd127671500, 32'hFFFFFFC1, 32'd0, 32'd0);
    send_planes(1, '{5, 0, 0, 1, 1, 1}, 1, '{angle: '0, status: ipa_pkg::STAT_ZERO});
    send_planes(0, '{1, 1, 1, 0, 0, 0}, 1, '{angle: '0, status: ipa_pkg::STAT_ZERO});
    random_planes(80);
    drain_results();

    load_cell(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd31, 32'd31, 32'd31);
    random_planes(100);
    drain_results();

    load_cell(32'd1, 32'd1, 32'd1, 32'd32, 32'd32, 32'd32);
    random_planes(100);
    drain_results();

    load_cell(32'hFFFFFFFF, 32'd1, 32'd0, 32'd1, 32'hFFFFFFFF, 32'd0);
    random_planes(100);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      load_cell($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      random_planes(100);
      drain_results();
    end

    if (errors == 0 && angle_q.size() == 0) begin
      $display("interplanar_angle_top regression: pass");
    end else begin
      $display("interplanar_angle_top regression: fail");
    end
    $finish;
  end

endmodule
